FILE: rtl/rgb_to_hsv_convert_unit_defines.svh
// Assertion macros shared by the RGB to HSV conversion RTL.
`ifndef RGB_TO_HSV_CONVERT_UNIT_DEFINES_SVH
`define RGB_TO_HSV_CONVERT_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Clocked check, off while reset is asserted.
`define RHSV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also runs during reset.
`define RHSV_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RHSV_ASSERT(lbl, clk, rst_n, prop, msg)
`define RHSV_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/rhsv_pkg.sv
// Shared constants and types for the RGB to HSV conversion unit.
package rhsv_pkg;

    localparam int HUE_FRAC_BITS = 6;
    localparam int HUE_W         = 15;
    localparam int CH_W          = 8;
    localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

    // Divider lanes
    localparam int LANES    = 2;
    localparam int LANE_HUE = 0;
    localparam int LANE_SAT = 1;

    // Hue sector codes
    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    // Fields that ride along with a word through the divider
    typedef struct packed {
        logic            neg;
        logic [1:0]      sec;
        logic [CH_W-1:0] value;
        logic [CH_W-1:0] alpha;
    } t_side;

endpackage

FILE: rtl/rgb_to_hsv_convert_unit.sv
// Top level of the streaming RGB to HSV conversion unit.
// Converts one packed RGBA word per clock into hue, saturation, value and
// alpha. Throughput is one word per cycle when the output side is ready.
// The registered stages are stage 1, stage 2, Q divider stages and the
// output stage, where Q is the larger of 8 and the bit width of
// 60 * 2^HUE_FRAC_BITS (Q = 12 at the default of 6). The divider resolves
// one quotient bit per stage for hue and saturation side by side. Stalls from
// the output side back up stage by stage, and empty stages keep filling
// while a result waits. Hue is degrees times 2^HUE_FRAC_BITS, low 15 bits.
`include "rgb_to_hsv_convert_unit_defines.svh"

module rgb_to_hsv_convert_unit #(
    parameter int HUE_FRAC_BITS = rhsv_pkg::HUE_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // packed_color[31:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // hue[14:0], saturation[22:15],
                                          // brightness[30:23], opacity[38:31]
);

    localparam int CH_W       = rhsv_pkg::CH_W;
    localparam int UNIT       = 1 << HUE_FRAC_BITS;
    localparam int SCALE      = 60 * UNIT;
    localparam int QUO_H_W    = $clog2(SCALE + 1);
    localparam int QUO_W      = (QUO_H_W > CH_W) ? QUO_H_W : CH_W;
    localparam int NUM_H_W    = $clog2(255 * SCALE + 1);
    localparam int NUM_W      = (NUM_H_W > 2 * CH_W) ? NUM_H_W : 2 * CH_W;
    localparam int HUE_INT_W  = $clog2(360 * UNIT);
    localparam int HUE_CALC_W = (HUE_INT_W > rhsv_pkg::HUE_W) ? HUE_INT_W : rhsv_pkg::HUE_W;

    localparam logic [HUE_INT_W-1:0] OFF_GREEN = HUE_INT_W'(120 * UNIT);
    localparam logic [HUE_INT_W-1:0] OFF_BLUE  = HUE_INT_W'(240 * UNIT);
    localparam logic [HUE_INT_W-1:0] FULL_TURN = HUE_INT_W'(360 * UNIT);

    // ---------------- stage 1: max, min, sector, difference ----------------
    logic [CH_W-1:0] red, green, blue;
    logic [CH_W-1:0] mx, mn, mag;
    logic [1:0]      sec;
    logic            neg;

    assign red   = i_s_axis_tdata[31:24];
    assign green = i_s_axis_tdata[23:16];
    assign blue  = i_s_axis_tdata[15:8];

    always_comb begin
        mx = red;
        mn = red;
        if (green > mx) mx = green;
        if (blue > mx)  mx = blue;
        if (green < mn) mn = green;
        if (blue < mn)  mn = blue;
        if (mx == red) begin
            sec = rhsv_pkg::SEC_RED;
            neg = green < blue;
            mag = neg ? blue - green : green - blue;
        end else if (mx == green) begin
            sec = rhsv_pkg::SEC_GREEN;
            neg = blue < red;
            mag = neg ? red - blue : blue - red;
        end else begin
            sec = rhsv_pkg::SEC_BLUE;
            neg = red < green;
            mag = neg ? green - red : red - green;
        end
    end

    logic            r1_vld;
    logic [CH_W-1:0] r1_mag, r1_delta, r1_max, r1_alpha;
    logic [1:0]      r1_sec;
    logic            r1_neg;
    logic            e1, e2, div_rdy, div_vld, rdy_out;

    assign e1 = !r1_vld || e2;
    assign o_s_axis_tready = e1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (e1) begin
            r1_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e1) begin
            r1_mag   <= mag;
            r1_delta <= mx - mn;
            r1_max   <= mx;
            r1_alpha <= i_s_axis_tdata[7:0];
            r1_sec   <= sec;
            r1_neg   <= neg;
        end
    end

    // ---------------- stage 2: numerators and divisors ----------------
    logic             r2_vld;
    logic [NUM_W-1:0] r2_num [rhsv_pkg::LANES];
    logic [CH_W-1:0]  r2_den [rhsv_pkg::LANES];
    rhsv_pkg::t_side  r2_side;

    assign e2 = !r2_vld || div_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (e2) begin
            r2_vld <= r1_vld;
        end
    end

    // Zero divisors only occur with zero numerators; divide by one instead.
    always_ff @(posedge i_clk) begin
        if (e2) begin
            r2_num[rhsv_pkg::LANE_HUE] <= NUM_W'(r1_mag) * NUM_W'(SCALE);
            r2_num[rhsv_pkg::LANE_SAT] <= NUM_W'(r1_delta) * NUM_W'(rhsv_pkg::CH_MAX);
            r2_den[rhsv_pkg::LANE_HUE] <= (r1_delta == '0) ? CH_W'(1) : r1_delta;
            r2_den[rhsv_pkg::LANE_SAT] <= (r1_max == '0) ? CH_W'(1) : r1_max;
            r2_side.neg   <= r1_neg;
            r2_side.sec   <= r1_sec;
            r2_side.value <= r1_max;
            r2_side.alpha <= r1_alpha;
        end
    end

    // ---------------- divider ----------------
    logic [QUO_W-1:0] div_quo [rhsv_pkg::LANES];
    rhsv_pkg::t_side  div_side;

    rhsv_div_pipe #(
        .NUM_W (NUM_W),
        .DEN_W (CH_W),
        .QUO_W (QUO_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_vld),
        .o_ready (div_rdy),
        .i_num   (r2_num),
        .i_den   (r2_den),
        .i_side  (r2_side),
        .o_valid (div_vld),
        .i_ready (rdy_out),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    // ---------------- output stage: sign, offset, wrap ----------------
    logic [HUE_INT_W-1:0]  q_hue, base, n_hue;
    logic                  r_o_vld;
    logic [HUE_CALC_W-1:0] r_hue;
    logic [CH_W-1:0]       r_sat, r_val, r_alpha;

    assign q_hue = HUE_INT_W'(div_quo[rhsv_pkg::LANE_HUE]);

    // A negative red-sector hue wraps by one full turn.
    always_comb begin
        case (div_side.sec)
            rhsv_pkg::SEC_RED:   base = (div_side.neg && q_hue != '0) ? FULL_TURN : '0;
            rhsv_pkg::SEC_GREEN: base = OFF_GREEN;
            rhsv_pkg::SEC_BLUE:  base = OFF_BLUE;
            default:             base = '0;
        endcase
        n_hue = div_side.neg ? base - q_hue : base + q_hue;
    end

    assign rdy_out = !r_o_vld || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (rdy_out) begin
            r_o_vld <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_out) begin
            r_hue   <= HUE_CALC_W'(n_hue);
            r_sat   <= div_quo[rhsv_pkg::LANE_SAT][CH_W-1:0];
            r_val   <= div_side.value;
            r_alpha <= div_side.alpha;
        end
    end

    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = {1'b0, r_alpha, r_val, r_sat, r_hue[rhsv_pkg::HUE_W-1:0]};

    `RHSV_ASSERT_NR(a_reset_empty, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "output valid right after reset")
    `RHSV_ASSERT(a_hue_range, i_clk, i_rst_n, r_o_vld |-> (r_hue < HUE_CALC_W'(FULL_TURN)), "hue at or above a full turn")
    `RHSV_ASSERT(a_black_zero, i_clk, i_rst_n, (r_o_vld && r_val == '0) |-> (r_sat == '0 && r_hue == '0), "black word with nonzero hue or saturation")
    `RHSV_ASSERT(a_grey_hue, i_clk, i_rst_n, (r_o_vld && r_sat == '0) |-> (r_hue == '0), "grey word with nonzero hue")

endmodule

FILE: rtl/rhsv_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes in lockstep.
`include "rgb_to_hsv_convert_unit_defines.svh"

module rhsv_div_pipe #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 8,
    parameter int QUO_W = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [NUM_W-1:0]     i_num [rhsv_pkg::LANES],
    input  logic [DEN_W-1:0]     i_den [rhsv_pkg::LANES],
    input  rhsv_pkg::t_side      i_side,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [QUO_W-1:0]     o_quo [rhsv_pkg::LANES],
    output rhsv_pkg::t_side      o_side
);

    localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [NUM_W-1:0]  s_rem  [QUO_W][rhsv_pkg::LANES];
    logic [QUO_W-1:0]  s_quo  [QUO_W][rhsv_pkg::LANES];
    logic [DEN_W-1:0]  s_den  [QUO_W][rhsv_pkg::LANES];
    rhsv_pkg::t_side   s_side [QUO_W];
    logic [QUO_W-1:0]  s_vld;
    logic [QUO_W:0]    stg_rdy;

    assign stg_rdy[QUO_W] = i_ready;

    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        localparam int SH = QUO_W - 1 - j;

        logic [NUM_W-1:0] src_rem [rhsv_pkg::LANES];
        logic [QUO_W-1:0] src_quo [rhsv_pkg::LANES];
        logic [DEN_W-1:0] src_den [rhsv_pkg::LANES];
        rhsv_pkg::t_side  src_side;
        logic             src_vld;
        logic [NUM_W-1:0] n_rem   [rhsv_pkg::LANES];
        logic [QUO_W-1:0] n_quo   [rhsv_pkg::LANES];
        logic [NUM_W-1:0] r_rem   [rhsv_pkg::LANES];
        logic [QUO_W-1:0] r_quo   [rhsv_pkg::LANES];
        logic [DEN_W-1:0] r_den   [rhsv_pkg::LANES];
        rhsv_pkg::t_side  r_side;
        logic             r_vld;

        if (j == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < rhsv_pkg::LANES; l++) begin
                    src_rem[l] = i_num[l];
                    src_quo[l] = '0;
                    src_den[l] = i_den[l];
                end
            end
            assign src_side = i_side;
            assign src_vld  = i_valid;
        end else begin : g_next
            always_comb begin
                for (int l = 0; l < rhsv_pkg::LANES; l++) begin
                    src_rem[l] = s_rem[j-1][l];
                    src_quo[l] = s_quo[j-1][l];
                    src_den[l] = s_den[j-1][l];
                end
            end
            assign src_side = s_side[j-1];
            assign src_vld  = s_vld[j-1];
        end

        // Try to take the shifted divisor out of the partial remainder.
        always_comb begin
            logic [CMP_W-1:0] trial;
            logic [CMP_W-1:0] rem_ext;
            for (int l = 0; l < rhsv_pkg::LANES; l++) begin
                trial   = CMP_W'(src_den[l]) << SH;
                rem_ext = CMP_W'(src_rem[l]);
                if (rem_ext >= trial) begin
                    n_rem[l] = NUM_W'(rem_ext - trial);
                    n_quo[l] = src_quo[l] | (QUO_W'(1) << SH);
                end else begin
                    n_rem[l] = src_rem[l];
                    n_quo[l] = src_quo[l];
                end
            end
        end

        assign stg_rdy[j] = !r_vld || stg_rdy[j+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (stg_rdy[j]) begin
                r_vld <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (stg_rdy[j]) begin
                r_rem  <= n_rem;
                r_quo  <= n_quo;
                r_den  <= src_den;
                r_side <= src_side;
            end
        end

        assign s_rem[j]  = r_rem;
        assign s_quo[j]  = r_quo;
        assign s_den[j]  = r_den;
        assign s_side[j] = r_side;
        assign s_vld[j]  = r_vld;
    end

    assign o_ready = stg_rdy[0];
    assign o_valid = s_vld[QUO_W-1];
    assign o_quo   = s_quo[QUO_W-1];
    assign o_side  = s_side[QUO_W-1];

    `RHSV_ASSERT(a_entry_fills, i_clk, i_rst_n, (i_valid && o_ready) |=> s_vld[0], "accepted word missing from first stage")
    `RHSV_ASSERT(a_den_nonzero, i_clk, i_rst_n, s_vld[0] |-> (s_den[0][rhsv_pkg::LANE_HUE] != '0 && s_den[0][rhsv_pkg::LANE_SAT] != '0), "zero divisor in divider")
    `RHSV_ASSERT(a_rem_bound, i_clk, i_rst_n, o_valid |-> (s_rem[QUO_W-1][rhsv_pkg::LANE_HUE] < NUM_W'(s_den[QUO_W-1][rhsv_pkg::LANE_HUE]) && s_rem[QUO_W-1][rhsv_pkg::LANE_SAT] < NUM_W'(s_den[QUO_W-1][rhsv_pkg::LANE_SAT])), "final remainder not below divisor")

endmodule
